@@ rtl/core/kspd_pkg.sv @@
// kspd_pkg: types, constants and key tables for the keypad scanner / PWM duty block.
// Used by keypad_scan_to_pwm_duty_top. No dependencies.
package kspd_pkg;

  // register indexes on the config port
  localparam logic [1:0] REG_SETTLE_TICKS = 2'd0;
  localparam logic [1:0] REG_HOLD_TICKS   = 2'd1;
  localparam logic [1:0] REG_PWM_PERIOD   = 2'd2;

  localparam logic [15:0] SETTLE_RESET = 16'd2;
  localparam logic [15:0] HOLD_RESET   = 16'd300;
  localparam logic [15:0] PERIOD_RESET = 16'd30000;
  localparam logic [15:0] DUTY_RESET   = 16'd3000;
  // PERIOD_RESET split into tenths
  localparam logic [12:0] PERIOD_Q10_RESET = 13'd3000;
  localparam logic [3:0]  PERIOD_R10_RESET = 4'd0;

  // x * RECIP10 >> RECIP10_SHIFT == x / 10 for every 16-bit x
  localparam logic [16:0] RECIP10       = 17'd52429;
  localparam int          RECIP10_SHIFT = 19;

  typedef enum logic [2:0] {
    PH_SCAN    = 3'b001,
    PH_RELEASE = 3'b010,
    PH_HOLD    = 3'b100
  } phase_t;

  typedef enum logic [1:0] {
    SC_KEEP,
    SC_TENTHS,
    SC_QUARTER,
    SC_THREE_QUARTER
  } scale_mode_t;

  typedef struct packed {
    scale_mode_t mode;
    logic [3:0]  tenths;
  } scale_t;

  typedef struct packed {
    logic [3:0]  row_drive;
    logic        key_valid;
    logic [7:0]  key_code;
    logic [15:0] duty_match;
  } res_t;

  // keymap, rows top to bottom: "123A" "456B" "789C" "*0#D"
  function automatic logic [7:0] key_char(input logic [3:0] k);
    logic [7:0] c;
    case (k)
      4'd0:    c = 8'h31;
      4'd1:    c = 8'h32;
      4'd2:    c = 8'h33;
      4'd3:    c = 8'h41;
      4'd4:    c = 8'h34;
      4'd5:    c = 8'h35;
      4'd6:    c = 8'h36;
      4'd7:    c = 8'h42;
      4'd8:    c = 8'h37;
      4'd9:    c = 8'h38;
      4'd10:   c = 8'h39;
      4'd11:   c = 8'h43;
      4'd12:   c = 8'h2A;
      4'd13:   c = 8'h30;
      4'd14:   c = 8'h23;
      default: c = 8'h44;
    endcase
    return c;
  endfunction

  // duty as a fraction of the period; '*' and '#' keep the duty
  function automatic scale_t key_scale(input logic [3:0] k);
    scale_t s;
    s.mode   = SC_TENTHS;
    s.tenths = 4'd0;
    case (k)
      4'd0:    s.tenths = 4'd2;
      4'd1:    s.tenths = 4'd3;
      4'd2:    s.tenths = 4'd4;
      4'd3:    s.mode   = SC_QUARTER;
      4'd4:    s.tenths = 4'd5;
      4'd5:    s.tenths = 4'd6;
      4'd6:    s.tenths = 4'd7;
      4'd7:    s.tenths = 4'd5;
      4'd8:    s.tenths = 4'd8;
      4'd9:    s.tenths = 4'd9;
      4'd10:   s.tenths = 4'd10;
      4'd11:   s.mode   = SC_THREE_QUARTER;
      4'd12:   s.mode   = SC_KEEP;
      4'd13:   s.tenths = 4'd1;
      4'd14:   s.mode   = SC_KEEP;
      default: s.tenths = 4'd9;
    endcase
    return s;
  endfunction

  // floor(x / 10) for x below 100
  function automatic logic [3:0] tenth_of(input logic [7:0] x);
    logic [3:0] q;
    q = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (x >= 8'(i * 10)) q = 4'(i);
    end
    return q;
  endfunction

endpackage

@@ rtl/core/keypad_scan_to_pwm_duty_top.sv @@
// Keypad row scanner with release detect and PWM duty update.
// Words are registered in the result register or skid; 1 word per cycle if skid empty.
// A two-entry output stage (result register plus skid) accepts one more word while a
// result waits. Sync active-high rst: row 0, scanning, duty 3000, registers to defaults.
// Duty = floor(period*pct/100), done as period tenths (split at config write) times n.
// Depends on kspd_pkg.
module keypad_scan_to_pwm_duty_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  column_levels,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  row_drive,
  output logic        key_valid,
  output logic [7:0]  key_code,
  output logic [15:0] duty_match,
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // config registers
  logic [15:0] settle_ticks;
  logic [15:0] hold_ticks;
  logic [15:0] pwm_period;
  logic [12:0] period_q10;
  logic [3:0]  period_r10;

  // scan state
  kspd_pkg::phase_t phase, phase_next;
  logic [1:0]  row_index, row_index_next;
  logic [15:0] tick_count, tick_count_next;
  logic [1:0]  held_column, held_column_next;
  logic [15:0] duty_value, duty_value_next;

  // output stage
  kspd_pkg::res_t res, skid, res_new;
  logic skid_valid;

  logic        accept;
  logic [15:0] count_inc;
  logic        settle_done, hold_done, released;
  logic [1:0]  low_col;
  logic [3:0]  key_idx;
  kspd_pkg::scale_t scale;
  logic [16:0] tenths_prod;
  logic [7:0]  frac_prod;
  logic [16:0] tenths_sum;
  logic [17:0] three_q;
  logic [15:0] new_duty;
  logic [32:0] cfg_prod;
  logic [12:0] cfg_q10;
  logic [15:0] cfg_r10_full;

  assign accept   = in_valid && in_ready;
  assign in_ready = !skid_valid;

  // split the period into tenths when written
  assign cfg_prod     = {17'd0, cfg_data} * {16'd0, kspd_pkg::RECIP10};
  assign cfg_q10      = cfg_prod[kspd_pkg::RECIP10_SHIFT +: 13];
  assign cfg_r10_full = cfg_data - ({cfg_q10, 3'b000} + {2'b00, cfg_q10, 1'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_ticks <= kspd_pkg::SETTLE_RESET;
      hold_ticks   <= kspd_pkg::HOLD_RESET;
      pwm_period   <= kspd_pkg::PERIOD_RESET;
      period_q10   <= kspd_pkg::PERIOD_Q10_RESET;
      period_r10   <= kspd_pkg::PERIOD_R10_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        kspd_pkg::REG_SETTLE_TICKS: settle_ticks <= cfg_data;
        kspd_pkg::REG_HOLD_TICKS:   hold_ticks   <= cfg_data;
        kspd_pkg::REG_PWM_PERIOD: begin
          pwm_period <= cfg_data;
          period_q10 <= cfg_q10;
          period_r10 <= cfg_r10_full[3:0];
        end
        default: ;
      endcase
    end
  end

  // scan step
  assign count_inc   = tick_count + 16'd1;
  // a wrapped count also ends the wait; zero settle acts like one
  assign settle_done = (count_inc >= settle_ticks) || (count_inc == 16'd0);
  assign hold_done   = (count_inc >= hold_ticks) || (count_inc == 16'd0);
  assign released    = !column_levels[held_column];
  assign low_col     = column_levels[0] ? 2'd0 :
                       column_levels[1] ? 2'd1 :
                       column_levels[2] ? 2'd2 : 2'd3;
  assign key_idx     = {row_index, held_column};
  assign scale       = kspd_pkg::key_scale(key_idx);

  // duty = q10*n + floor(r10*n/10)
  assign tenths_prod = {4'd0, period_q10} * {13'd0, scale.tenths};
  assign frac_prod   = {4'd0, period_r10} * {4'd0, scale.tenths};
  assign tenths_sum  = tenths_prod + {13'd0, kspd_pkg::tenth_of(frac_prod)};
  assign three_q     = {2'b00, pwm_period} + {1'b0, pwm_period, 1'b0};

  always_comb begin
    case (scale.mode)
      kspd_pkg::SC_TENTHS:        new_duty = tenths_sum[15:0];
      kspd_pkg::SC_QUARTER:       new_duty = {2'b00, pwm_period[15:2]};
      kspd_pkg::SC_THREE_QUARTER: new_duty = three_q[17:2];
      default:                    new_duty = duty_value;
    endcase
  end

  always_comb begin
    phase_next       = phase;
    row_index_next   = row_index;
    tick_count_next  = tick_count;
    held_column_next = held_column;
    duty_value_next  = duty_value;
    res_new.row_drive = 4'b0001 << row_index;
    res_new.key_valid = 1'b0;
    res_new.key_code  = 8'd0;
    case (phase)
      kspd_pkg::PH_SCAN: begin
        if (settle_done) begin
          tick_count_next = 16'd0;
          if (column_levels != 4'd0) begin
            held_column_next = low_col;
            phase_next       = kspd_pkg::PH_RELEASE;
          end else begin
            row_index_next = row_index + 2'd1;
          end
        end else begin
          tick_count_next = count_inc;
        end
      end
      kspd_pkg::PH_RELEASE: begin
        if (released) begin
          res_new.key_valid = 1'b1;
          res_new.key_code  = kspd_pkg::key_char(key_idx);
          duty_value_next   = new_duty;
          tick_count_next   = 16'd0;
          if (hold_ticks == 16'd0) begin
            phase_next     = kspd_pkg::PH_SCAN;
            row_index_next = 2'd0;
          end else begin
            phase_next = kspd_pkg::PH_HOLD;
          end
        end
      end
      default: begin
        if (hold_done) begin
          phase_next      = kspd_pkg::PH_SCAN;
          row_index_next  = 2'd0;
          tick_count_next = 16'd0;
        end else begin
          tick_count_next = count_inc;
        end
      end
    endcase
    res_new.duty_match = duty_value_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= kspd_pkg::PH_SCAN;
      row_index   <= 2'd0;
      tick_count  <= 16'd0;
      held_column <= 2'd0;
      duty_value  <= kspd_pkg::DUTY_RESET;
    end else if (accept) begin
      phase       <= phase_next;
      row_index   <= row_index_next;
      tick_count  <= tick_count_next;
      held_column <= held_column_next;
      duty_value  <= duty_value_next;
    end
  end

  // result register with skid; skid fills only while the result word is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        res <= skid;
      end else if (accept) begin
        res <= res_new;
      end
    end else if (accept) begin
      skid <= res_new;
    end
  end

  assign row_drive  = res.row_drive;
  assign key_valid  = res.key_valid;
  assign key_code   = res.key_code;
  assign duty_match = res.duty_match;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a word while the result register is empty");

  a_code_only_on_report: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !key_valid) |-> (key_code == 8'd0))
    else $error("key code set without a key report");

  a_row_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot(row_drive))
    else $error("row drive not one-hot");

  a_report_leaves_release: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == kspd_pkg::PH_RELEASE && released) |=>
      (phase != kspd_pkg::PH_RELEASE))
    else $error("still waiting for release after a report");

  a_duty_moves_on_accept: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(duty_value))
    else $error("duty changed without an accepted word");

endmodule

@@ tb/keypad_scan_to_pwm_duty_top_tb.sv @@
// Self-checking testbench for keypad_scan_to_pwm_duty_top: drives column words, checks
// row drive, key reports and duty match against a word-by-word scan/duty predictor.
// Depends on kspd_pkg and the keypad_scan_to_pwm_duty_top RTL.
module keypad_scan_to_pwm_duty_top_tb;

  localparam int         CYCLE_LIMIT     = 200000;
  localparam int         KEEP_DUTY       = 0;
  localparam logic [1:0] REG_UNUSED      = 2'd3;
  localparam int         RAND_PHASES     = 6;
  localparam int         WORDS_PER_PHASE = 75;
  localparam int         MAX_REPORTS     = 10;

  // Tracks scan state and duty, queues the expected result words.
  class duty_scoreboard;
    kspd_pkg::res_t   pending_words[$];
    kspd_pkg::phase_t ph;
    logic [1:0]  row;
    logic [1:0]  held;
    logic [15:0] cnt;
    logic [15:0] duty;
    logic [15:0] settle;
    logic [15:0] hold;
    logic [15:0] period;
    int unsigned ticks;
    int unsigned keys;
    int unsigned failures;
    logic [15:0] keys_seen;
    string       keymap = "123A456B789C*0#D";
    byte unsigned key_pct[16] = '{20, 30, 40, 25, 50, 60, 70, 50,
                                  80, 90, 100, 75, KEEP_DUTY, 10, KEEP_DUTY, 90};

    function new();
      settle    = kspd_pkg::SETTLE_RESET;
      hold      = kspd_pkg::HOLD_RESET;
      period    = kspd_pkg::PERIOD_RESET;
      duty      = kspd_pkg::DUTY_RESET;
      held      = 2'd0;
      ticks     = 0;
      keys      = 0;
      failures  = 0;
      keys_seen = '0;
      restart_scan();
    endfunction

    function void restart_scan();
      ph  = kspd_pkg::PH_SCAN;
      row = 2'd0;
      cnt = 16'd0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        kspd_pkg::REG_SETTLE_TICKS: settle = val;
        kspd_pkg::REG_HOLD_TICKS:   hold = val;
        kspd_pkg::REG_PWM_PERIOD:   period = val;
        default: ;
      endcase
    endfunction

    function void note_tick(logic [3:0] cols);
      kspd_pkg::res_t r;
      logic [15:0] next_cnt;
      logic [3:0]  k;
      int unsigned pct;
      r.row_drive = 4'b0001 << row;
      r.key_valid = 1'b0;
      r.key_code  = 8'h00;
      ticks++;
      case (ph)
        kspd_pkg::PH_SCAN: begin
          next_cnt = cnt + 16'd1;
          // a settle of zero samples on the first tick, like one
          if (next_cnt >= settle || next_cnt == 16'd0) begin
            if (cols != 4'd0) begin
              held = 2'd3;
              for (int c = 2; c >= 0; c--) if (cols[c]) held = 2'(c);
              ph = kspd_pkg::PH_RELEASE;
            end else begin
              row = row + 2'd1;
            end
            cnt = 16'd0;
          end else begin
            cnt = next_cnt;
          end
        end
        kspd_pkg::PH_RELEASE: begin
          // only the latched column matters here
          if (!cols[held]) begin
            k = {row, held};
            pct = key_pct[k];
            r.key_valid = 1'b1;
            r.key_code  = keymap[k];
            keys++;
            keys_seen[k] = 1'b1;
            if (pct != KEEP_DUTY) duty = 16'((32'(period) * pct) / 100);
            if (hold == 16'd0) begin
              restart_scan();
            end else begin
              ph  = kspd_pkg::PH_HOLD;
              cnt = 16'd0;
            end
          end
        end
        default: begin
          next_cnt = cnt + 16'd1;
          if (next_cnt >= hold || next_cnt == 16'd0) restart_scan();
          else cnt = next_cnt;
        end
      endcase
      r.duty_match = duty;
      pending_words.push_back(r);
    endfunction

    function void check_result(kspd_pkg::res_t got);
      kspd_pkg::res_t want;
      if (pending_words.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected result word: row %h valid %b key %h duty %0d",
                   got.row_drive, got.key_valid, got.key_code, got.duty_match);
        return;
      end
      want = pending_words.pop_front();
      if (got.row_drive !== want.row_drive || got.key_valid !== want.key_valid ||
          got.key_code !== want.key_code || got.duty_match !== want.duty_match) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display({"mismatch: expected row %h valid %b key %h duty %0d, ",
                    "got row %h valid %b key %h duty %0d"},
                   want.row_drive, want.key_valid, want.key_code, want.duty_match,
                   got.row_drive, got.key_valid, got.key_code, got.duty_match);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  column_levels = 4'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  row_drive;
  logic        key_valid;
  logic [7:0]  key_code;
  logic [15:0] duty_match;
  logic        cfg_write_en = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_data = 16'd0;

  duty_scoreboard sb;
  int unsigned    cycle_count = 0;
  int unsigned    tx_idle_pct = 15;
  int unsigned    rx_idle_pct = 69;
  int unsigned    press_left = 0;
  logic [3:0]     press_mask = 4'd0;

  int unsigned mode_settle[RAND_PHASES] = '{1, 3, 2, 0, 4, 1};
  int unsigned mode_hold[RAND_PHASES]   = '{3, 0, 5, 1, 2, 0};
  int unsigned mode_period[RAND_PHASES] = '{30000, 1, 65535, 12345, 0, 0};

  keypad_scan_to_pwm_duty_top uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .column_levels(column_levels),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .row_drive    (row_drive),
    .key_valid    (key_valid),
    .key_code     (key_code),
    .duty_match   (duty_match),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin : monitor
    kspd_pkg::res_t got;
    if (!rst) begin
      if (in_valid && in_ready) sb.note_tick(column_levels);
      if (out_valid && out_ready) begin
        got = {row_drive, key_valid, key_code, duty_match};
        sb.check_result(got);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", cycle_count);
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_word(input logic [3:0] levels);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    column_levels <= levels;
    do @(posedge clk); while (!in_ready);
  endtask

  // sender holds off until every queued word has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // leaves the write enable high; caller lowers it after the last write
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [15:0] settle, input logic [15:0] hold,
                          input logic [15:0] period);
    write_reg(kspd_pkg::REG_SETTLE_TICKS, settle);
    write_reg(kspd_pkg::REG_HOLD_TICKS, hold);
    write_reg(kspd_pkg::REG_PWM_PERIOD, period);
    write_reg(REG_UNUSED, 16'($urandom));
    cfg_write_en <= 1'b0;
  endtask

  // mostly clean press/release gestures, some raw noise
  function automatic logic [3:0] next_levels();
    int unsigned roll;
    logic [3:0]  v;
    roll = $urandom_range(0, 99);
    if (roll < 15) return 4'($urandom);
    if (press_left > 0) begin
      press_left--;
      v = press_mask;
      if (roll < 25) v = v | 4'($urandom);
      return v;
    end
    if (roll < 40) begin
      press_mask = (roll < 32) ? (4'b0001 << $urandom_range(0, 3))
                               : 4'($urandom_range(1, 15));
      press_left = $urandom_range(0, int'(sb.settle) + 3);
      return press_mask;
    end
    return 4'd0;
  endfunction

  initial begin : stimulus
    logic [3:0]  directed_words[$];
    int unsigned period;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: scan past row 0, press on row 1, report, then sit in hold
    directed_words = '{4'h0, 4'h0, 4'h1, 4'h1, 4'h0, 4'h0, 4'h0};
    foreach (directed_words[i]) send_word(directed_words[i]);
    wait_drained();

    // zero settle and hold; hold ends at once under the new value
    set_regs(16'd0, 16'd0, 16'd65535);
    directed_words = '{4'h0, 4'hF, 4'hE, 4'h0, 4'h0, 4'h8, 4'h8, 4'h7,
                       4'h0, 4'h0, 4'h0, 4'h1, 4'h0, 4'h2, 4'hF, 4'hD};
    foreach (directed_words[i]) send_word(directed_words[i]);
    wait_drained();

    // longest counts, cut short by rewriting the register mid-count
    write_reg(kspd_pkg::REG_SETTLE_TICKS, 16'hFFFF);
    write_reg(kspd_pkg::REG_HOLD_TICKS, 16'hFFFF);
    cfg_write_en <= 1'b0;
    repeat (6) send_word(4'hF);
    wait_drained();
    write_reg(kspd_pkg::REG_SETTLE_TICKS, 16'd1);
    cfg_write_en <= 1'b0;
    send_word(4'hF);
    repeat (5) send_word(4'h0);
    wait_drained();
    write_reg(kspd_pkg::REG_HOLD_TICKS, 16'd2);
    cfg_write_en <= 1'b0;
    repeat (3) send_word(4'h0);
    wait_drained();

    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == 2) begin
        tx_idle_pct = 69;
        rx_idle_pct = 15;
      end else if (p == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      period = (mode_period[p] == 0) ? $urandom_range(1, 65535) : mode_period[p];
      set_regs(16'(mode_settle[p]), 16'(mode_hold[p]), 16'(period));
      press_left = 0;
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        send_word(next_levels());
        if (i == WORDS_PER_PHASE / 2 && p % 2 == 0) wait_drained();
      end
      wait_drained();
    end

    repeat (4) @(posedge clk);
    if (sb.pending_words.size() != 0) begin
      $display("%0d expected words never arrived", sb.pending_words.size());
      sb.failures++;
    end
    $display("ran %0d tick words over %0d register settings;",
             sb.ticks, RAND_PHASES + 4);
    $display("%0d key reports, %0d of 16 keys hit",
             sb.keys, $countones(sb.keys_seen));
    $display("failures: %0d, cycles: %0d", sb.failures, cycle_count);
    if (sb.failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
